// ===== design/fbm_pkg.sv =====
// shared types, constants and register codes for the fsk bus modem
package fbm_pkg;

    localparam int MAX_BYTES  = 16;
    localparam int IDX_W      = (MAX_BYTES > 1) ? $clog2(MAX_BYTES) : 1;
    localparam int LEN_W      = $clog2(MAX_BYTES + 1);
    localparam int FBI_W      = 4;
    localparam int ADDR_W     = 5;
    localparam int FRAME_BITS = 12;

    localparam logic [FBI_W-1:0] FB_START  = 4'd0;
    localparam logic [FBI_W-1:0] FB_ZERO   = 4'd1;
    localparam logic [FBI_W-1:0] FB_DATA0  = 4'd2;
    localparam logic [FBI_W-1:0] FB_PARITY = 4'd10;
    localparam logic [FBI_W-1:0] FB_STOP   = 4'd11;

    localparam logic [15:0] RST_MIN_GAP          = 16'd200;
    localparam logic [15:0] RST_TIMEOUT_TICKS    = 16'd500;
    localparam logic [15:0] RST_BIT_THRESHOLD    = 16'd336;
    localparam logic [15:0] RST_HALF_PERIOD_ONE  = 16'd143;
    localparam logic [15:0] RST_HALF_PERIOD_ZERO = 16'd193;
    localparam logic [15:0] RST_RELOAD_VALUE     = 16'd24;
    localparam logic [15:0] RST_BIT_TICKS        = 16'd12200;

    typedef enum logic [2:0] {
        REG_MIN_GAP          = 3'd0,
        REG_TIMEOUT_TICKS    = 3'd1,
        REG_BIT_THRESHOLD    = 3'd2,
        REG_HALF_PERIOD_ONE  = 3'd3,
        REG_HALF_PERIOD_ZERO = 3'd4,
        REG_RELOAD_VALUE     = 3'd5,
        REG_BIT_TICKS        = 3'd6
    } reg_idx_t;

    typedef struct packed {
        logic       opcode;
        logic       rx_falling_edge;
        logic [7:0] send_byte;
        logic       last_byte;
    } in_item_t;

    typedef struct packed {
        logic data_out;
        logic drive_a;
        logic drive_b;
        logic drive_enable;
        logic heartbeat;
        logic busy_res;
    } out_item_t;

    typedef struct packed {
        logic [15:0] min_gap;
        logic [15:0] timeout_ticks;
        logic [15:0] bit_threshold;
        logic [15:0] half_period_one;
        logic [15:0] half_period_zero;
        logic [15:0] reload_value;
        logic [15:0] bit_ticks;
    } cfg_t;

    typedef struct packed {
        logic        load;
        logic [15:0] value;
    } cfg_load_t;

endpackage

// ===== design/fsk_bus_modem_unit.sv =====
// top level of the fsk bus modem: handshake, result register, config port
// Each input transfer is one timer tick or one byte load and yields exactly one result
// transfer, which is written into the result register by the clock edge that takes the input.
// A new item is taken every cycle (one item per clock) as long as the result register is
// empty or its contents are taken in the same cycle; the rate is set by the single state
// update of counter, receive decoder and send sequencer per item. The 16-entry message
// store needs no clearing after reset; only bytes that were loaded are ever sent.
module fsk_bus_modem_unit (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  fbm_pkg::in_item_t          s_data,
    output logic                       m_valid,
    input  logic                       m_ready,
    output fbm_pkg::out_item_t         m_data,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [fbm_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]                pwdata,
    output logic [31:0]                prdata,
    output logic                       pready
);

    fbm_pkg::cfg_t      cfg;
    fbm_pkg::cfg_load_t tout_load;
    fbm_pkg::out_item_t res_next;
    fbm_pkg::out_item_t m_data_reg;
    logic               m_valid_reg;
    logic               s_fire;

    assign s_ready = !m_valid_reg || m_ready;
    assign s_fire  = s_valid && s_ready;

    fbm_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .cfg       (cfg),
        .tout_load (tout_load)
    );

    fbm_core u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_fire   (s_fire),
        .item      (s_data),
        .cfg       (cfg),
        .tout_load (tout_load),
        .res_next  (res_next)
    );

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (s_fire) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            m_data_reg <= res_next;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

`ifndef SYNTHESIS
    a_fire_gives_result: assert property (@(posedge aclk) disable iff (!aresetn)
        s_fire |=> m_valid)
        else $error("accepted transfer produced no result");

    a_tones_complementary: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.busy_res) |-> (m_data.drive_a != m_data.drive_b))
        else $error("drive lines not complementary while sending");

    a_tones_idle_low: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_data.busy_res) |-> (!m_data.drive_a && !m_data.drive_b))
        else $error("drive lines active while not sending");

    a_enable_follows_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_data.drive_enable == m_data.busy_res))
        else $error("drive enable differs from busy");
`endif

endmodule

// ===== design/fbm_cfg.sv =====
// apb configuration registers of the fsk bus modem
module fbm_cfg (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  logic [fbm_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]               pwdata,
    output logic [31:0]               prdata,
    output logic                      pready,
    output fbm_pkg::cfg_t             cfg,
    output fbm_pkg::cfg_load_t        tout_load
);

    fbm_pkg::cfg_t   cfg_reg;
    fbm_pkg::cfg_t   cfg_next;
    logic            wr_en;
    logic [2:0]      idx;
    logic [15:0]     wval;

    assign pready = 1'b1;
    assign wr_en  = psel & penable & pwrite & pready;
    assign idx    = paddr[4:2];
    assign wval   = pwdata[15:0];

    always_comb begin
        cfg_next = cfg_reg;
        if (wr_en) begin
            unique case (idx)
                fbm_pkg::REG_MIN_GAP:          cfg_next.min_gap          = wval;
                fbm_pkg::REG_TIMEOUT_TICKS:    cfg_next.timeout_ticks    = wval;
                fbm_pkg::REG_BIT_THRESHOLD:    cfg_next.bit_threshold    = wval;
                fbm_pkg::REG_HALF_PERIOD_ONE:  cfg_next.half_period_one  = wval;
                fbm_pkg::REG_HALF_PERIOD_ZERO: cfg_next.half_period_zero = wval;
                fbm_pkg::REG_RELOAD_VALUE:     cfg_next.reload_value     = wval;
                fbm_pkg::REG_BIT_TICKS:        cfg_next.bit_ticks        = wval;
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (idx)
            fbm_pkg::REG_MIN_GAP:          prdata = {16'd0, cfg_reg.min_gap};
            fbm_pkg::REG_TIMEOUT_TICKS:    prdata = {16'd0, cfg_reg.timeout_ticks};
            fbm_pkg::REG_BIT_THRESHOLD:    prdata = {16'd0, cfg_reg.bit_threshold};
            fbm_pkg::REG_HALF_PERIOD_ONE:  prdata = {16'd0, cfg_reg.half_period_one};
            fbm_pkg::REG_HALF_PERIOD_ZERO: prdata = {16'd0, cfg_reg.half_period_zero};
            fbm_pkg::REG_RELOAD_VALUE:     prdata = {16'd0, cfg_reg.reload_value};
            fbm_pkg::REG_BIT_TICKS:        prdata = {16'd0, cfg_reg.bit_ticks};
            default:                       prdata = 32'd0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.min_gap          <= fbm_pkg::RST_MIN_GAP;
            cfg_reg.timeout_ticks    <= fbm_pkg::RST_TIMEOUT_TICKS;
            cfg_reg.bit_threshold    <= fbm_pkg::RST_BIT_THRESHOLD;
            cfg_reg.half_period_one  <= fbm_pkg::RST_HALF_PERIOD_ONE;
            cfg_reg.half_period_zero <= fbm_pkg::RST_HALF_PERIOD_ZERO;
            cfg_reg.reload_value     <= fbm_pkg::RST_RELOAD_VALUE;
            cfg_reg.bit_ticks        <= fbm_pkg::RST_BIT_TICKS;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg             = cfg_reg;
    assign tout_load.load  = wr_en && (idx == fbm_pkg::REG_TIMEOUT_TICKS);
    assign tout_load.value = wval;

endmodule

// ===== design/fbm_frame.sv =====
// frame bit selector: start, zero, data lsb first, even parity, stop
module fbm_frame (
    input  logic [7:0]                cur_byte,
    input  logic [fbm_pkg::FBI_W-1:0] bit_idx,
    output logic                      frame_bit
);

    logic [2:0] sel;

    assign sel = 3'(bit_idx - fbm_pkg::FB_DATA0);

    always_comb begin
        if (bit_idx == fbm_pkg::FB_START || bit_idx >= fbm_pkg::FB_STOP) begin
            frame_bit = 1'b1;
        end else if (bit_idx == fbm_pkg::FB_ZERO) begin
            frame_bit = 1'b0;
        end else if (bit_idx == fbm_pkg::FB_PARITY) begin
            frame_bit = ^cur_byte;
        end else begin
            frame_bit = cur_byte[sel];
        end
    end

endmodule

// ===== design/fbm_core.sv =====
// modem state: period counter, receive decoder, send sequencer and message store
module fbm_core (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 in_fire,
    input  fbm_pkg::in_item_t    item,
    input  fbm_pkg::cfg_t        cfg,
    input  fbm_pkg::cfg_load_t   tout_load,
    output fbm_pkg::out_item_t   res_next
);

    logic [15:0]                 pc_reg, pc_next;
    logic [15:0]                 cv_reg, cv_next;
    logic [2:0]                  hist_reg, hist_next;
    logic                        line_reg, line_next;
    logic                        hb_reg, hb_next;
    logic                        sending_reg, sending_next;
    logic                        leading_reg, leading_next;
    logic                        ta_reg, ta_next;
    logic                        tb_reg, tb_next;
    logic [fbm_pkg::LEN_W-1:0]   len_reg, len_next;
    logic [fbm_pkg::LEN_W-1:0]   cbi_reg, cbi_next;
    logic [fbm_pkg::FBI_W-1:0]   fbi_reg, fbi_next;
    logic [15:0]                 btc_reg, btc_next;

    logic [7:0]                  store_mem [fbm_pkg::MAX_BYTES];
    logic                        st_we;
    logic [7:0]                  cur_byte_reg;

    logic [fbm_pkg::LEN_W-1:0]   cbi_adv;
    logic [fbm_pkg::FBI_W-1:0]   fbi_adv;
    logic [fbm_pkg::FBI_W-1:0]   fbi_inc;
    logic [fbm_pkg::FBI_W-1:0]   fbi_nxt_inc;
    logic [fbm_pkg::LEN_W-1:0]   rd_cbi;
    logic [fbm_pkg::IDX_W-1:0]   rd_addr;
    logic                        frame_bit;

    // position of the next bit once the current one has run out
    always_comb begin
        fbi_inc = fbi_reg + 4'd1;
        if (leading_reg) begin
            cbi_adv = '0;
            fbi_adv = '0;
        end else if (fbi_inc >= fbm_pkg::FBI_W'(fbm_pkg::FRAME_BITS)) begin
            cbi_adv = cbi_reg + fbm_pkg::LEN_W'(1);
            fbi_adv = '0;
        end else begin
            cbi_adv = cbi_reg;
            fbi_adv = fbi_inc;
        end
    end

    // byte that the following bit advance will need, fetched ahead into a register
    always_comb begin
        fbi_nxt_inc = fbi_next + 4'd1;
        if (leading_next) begin
            rd_cbi = '0;
        end else if (fbi_nxt_inc >= fbm_pkg::FBI_W'(fbm_pkg::FRAME_BITS)) begin
            rd_cbi = cbi_next + fbm_pkg::LEN_W'(1);
        end else begin
            rd_cbi = cbi_next;
        end
    end

    assign rd_addr = rd_cbi[fbm_pkg::IDX_W-1:0];

    fbm_frame u_frame (
        .cur_byte  (cur_byte_reg),
        .bit_idx   (fbi_adv),
        .frame_bit (frame_bit)
    );

    always_comb begin
        logic                      accepted;
        logic [2:0]                h;
        logic [15:0]               pc1;
        logic [15:0]               btc1;
        logic [15:0]               cv_new;
        logic [fbm_pkg::LEN_W-1:0] len_w;

        pc_next      = pc_reg;
        cv_next      = cv_reg;
        hist_next    = hist_reg;
        line_next    = line_reg;
        hb_next      = hb_reg;
        sending_next = sending_reg;
        leading_next = leading_reg;
        ta_next      = ta_reg;
        tb_next      = tb_reg;
        len_next     = len_reg;
        cbi_next     = cbi_reg;
        fbi_next     = fbi_reg;
        btc_next     = btc_reg;
        st_we        = 1'b0;
        accepted     = 1'b0;
        h            = '0;
        pc1          = '0;
        btc1         = '0;
        cv_new       = '0;
        len_w        = len_reg;

        if (in_fire && !item.opcode) begin
            accepted = !sending_reg && item.rx_falling_edge && (pc_reg >= cfg.min_gap);
            if (accepted && (pc_reg < cfg.timeout_ticks)) begin
                h         = {hist_reg[1:0], pc_reg > cfg.bit_threshold};
                hist_next = h;
                line_next = (h < 3'd3) || (h == 3'd4);
            end
            pc1 = accepted ? 16'd0 : pc_reg + 16'd1;
            if (pc1 == cv_reg) begin
                pc1       = cfg.reload_value;
                hist_next = '0;
                if (sending_reg) begin
                    ta_next = ~ta_reg;
                    tb_next = ~tb_reg;
                end else begin
                    line_next = 1'b1;
                    hb_next   = ~hb_reg;
                end
            end
            pc_next = pc1;
            if (sending_reg) begin
                btc1     = btc_reg + 16'd1;
                btc_next = btc1;
                if (btc1 >= cfg.bit_ticks) begin
                    leading_next = 1'b0;
                    if (cbi_adv >= len_reg) begin
                        ta_next      = 1'b0;
                        tb_next      = 1'b0;
                        sending_next = 1'b0;
                        cv_next      = cfg.timeout_ticks;
                        len_next     = '0;
                        cbi_next     = '0;
                        fbi_next     = '0;
                        btc_next     = '0;
                    end else begin
                        cbi_next  = cbi_adv;
                        fbi_next  = fbi_adv;
                        cv_new    = frame_bit ? cfg.half_period_one : cfg.half_period_zero;
                        cv_next   = cv_new;
                        line_next = frame_bit;
                        if (pc1 >= cv_new) begin
                            pc_next = cv_new - 16'd1;
                        end
                        btc_next  = '0;
                    end
                end
            end
        end else if (in_fire && !sending_reg) begin
            if (len_reg < fbm_pkg::LEN_W'(fbm_pkg::MAX_BYTES)) begin
                st_we = 1'b1;
                len_w = len_reg + fbm_pkg::LEN_W'(1);
            end
            len_next = len_w;
            if (item.last_byte && (len_w != '0)) begin
                ta_next      = 1'b1;
                tb_next      = 1'b0;
                sending_next = 1'b1;
                leading_next = 1'b1;
                cbi_next     = '0;
                fbi_next     = '0;
                cv_next      = cfg.half_period_one;
                line_next    = 1'b1;
                pc_next      = (cfg.half_period_one == 16'd0) ? 16'hFFFF : 16'd0;
                btc_next     = '0;
            end
        end

        if (tout_load.load && !sending_reg) begin
            cv_next = tout_load.value;
        end
    end

    // message store, read first with the byte being written passed through
    always_ff @(posedge aclk) begin
        if (st_we) begin
            store_mem[len_reg[fbm_pkg::IDX_W-1:0]] <= item.send_byte;
        end
        if (st_we && (rd_addr == len_reg[fbm_pkg::IDX_W-1:0])) begin
            cur_byte_reg <= item.send_byte;
        end else begin
            cur_byte_reg <= store_mem[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pc_reg      <= '0;
            cv_reg      <= fbm_pkg::RST_TIMEOUT_TICKS;
            hist_reg    <= '0;
            line_reg    <= 1'b0;
            hb_reg      <= 1'b0;
            sending_reg <= 1'b0;
            leading_reg <= 1'b0;
            ta_reg      <= 1'b0;
            tb_reg      <= 1'b0;
            len_reg     <= '0;
            cbi_reg     <= '0;
            fbi_reg     <= '0;
            btc_reg     <= '0;
        end else begin
            pc_reg      <= pc_next;
            cv_reg      <= cv_next;
            hist_reg    <= hist_next;
            line_reg    <= line_next;
            hb_reg      <= hb_next;
            sending_reg <= sending_next;
            leading_reg <= leading_next;
            ta_reg      <= ta_next;
            tb_reg      <= tb_next;
            len_reg     <= len_next;
            cbi_reg     <= cbi_next;
            fbi_reg     <= fbi_next;
            btc_reg     <= btc_next;
        end
    end

    assign res_next.data_out     = line_next;
    assign res_next.drive_a      = ta_next;
    assign res_next.drive_b      = tb_next;
    assign res_next.drive_enable = sending_next;
    assign res_next.heartbeat    = hb_next;
    assign res_next.busy_res     = sending_next;

endmodule

// ===== dv/tb_top.sv =====
// testbench for fsk_bus_modem_unit: directed and random tick and load traffic, self-checking
module tb_top;

    localparam int   CYCLE_LIMIT = 200000;
    localparam int   IDLE_PCT    = 15;
    localparam logic OP_TICK     = 1'b0;
    localparam logic OP_LOAD     = 1'b1;

    logic                       aclk;
    logic                       aresetn;
    logic                       s_valid;
    logic                       s_ready;
    fbm_pkg::in_item_t          s_data;
    logic                       m_valid;
    logic                       m_ready;
    fbm_pkg::out_item_t         m_data;
    logic                       psel;
    logic                       penable;
    logic                       pwrite;
    logic [fbm_pkg::ADDR_W-1:0] paddr;
    logic [31:0]                pwdata;
    logic [31:0]                prdata;
    logic                       pready;

    fsk_bus_modem_unit dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // modem model state
    fbm_pkg::cfg_t regs;
    logic [15:0]   tick_ctr;
    logic [15:0]   cmp_val;
    logic [15:0]   bit_ctr;
    logic [2:0]    rx_hist;
    logic          line_q;
    logic          hb_q;
    logic          tx_on;
    logic          tone_a_q;
    logic          tone_b_q;
    logic          lead_q;
    logic [7:0]    msg_mem [fbm_pkg::MAX_BYTES];
    int            msg_len;
    int            byte_pos;
    int            frame_pos;

    fbm_pkg::out_item_t expected_outputs [$];
    fbm_pkg::in_item_t  input_backlog [$];
    logic               holding;
    int                 s_idle_pct;
    int                 m_idle_pct;
    int                 items_queued;
    int                 items_taken;
    int                 results_done;
    int                 errors;
    int                 cycle_count;
    int                 tx_messages;
    int                 rx_bits;
    int                 rx_timeouts;

    function automatic void modem_reset();
        regs.min_gap          = fbm_pkg::RST_MIN_GAP;
        regs.timeout_ticks    = fbm_pkg::RST_TIMEOUT_TICKS;
        regs.bit_threshold    = fbm_pkg::RST_BIT_THRESHOLD;
        regs.half_period_one  = fbm_pkg::RST_HALF_PERIOD_ONE;
        regs.half_period_zero = fbm_pkg::RST_HALF_PERIOD_ZERO;
        regs.reload_value     = fbm_pkg::RST_RELOAD_VALUE;
        regs.bit_ticks        = fbm_pkg::RST_BIT_TICKS;
        tick_ctr  = '0;
        cmp_val   = fbm_pkg::RST_TIMEOUT_TICKS;
        bit_ctr   = '0;
        rx_hist   = '0;
        line_q    = 1'b0;
        hb_q      = 1'b0;
        tx_on     = 1'b0;
        tone_a_q  = 1'b0;
        tone_b_q  = 1'b0;
        lead_q    = 1'b0;
        msg_len   = 0;
        byte_pos  = 0;
        frame_pos = 0;
    endfunction

    function automatic void modem_write(fbm_pkg::reg_idx_t idx, logic [15:0] v);
        case (idx)
            fbm_pkg::REG_MIN_GAP: regs.min_gap = v;
            fbm_pkg::REG_TIMEOUT_TICKS: begin
                regs.timeout_ticks = v;
                if (!tx_on) cmp_val = v;
            end
            fbm_pkg::REG_BIT_THRESHOLD:    regs.bit_threshold = v;
            fbm_pkg::REG_HALF_PERIOD_ONE:  regs.half_period_one = v;
            fbm_pkg::REG_HALF_PERIOD_ZERO: regs.half_period_zero = v;
            fbm_pkg::REG_RELOAD_VALUE:     regs.reload_value = v;
            fbm_pkg::REG_BIT_TICKS:        regs.bit_ticks = v;
            default: ;
        endcase
    endfunction

    function automatic logic frame_level();
        logic [7:0] b;
        b = (byte_pos < fbm_pkg::MAX_BYTES) ? msg_mem[byte_pos] : 8'h00;
        if (frame_pos == fbm_pkg::FB_START || frame_pos >= fbm_pkg::FB_STOP) return 1'b1;
        if (frame_pos == fbm_pkg::FB_ZERO) return 1'b0;
        if (frame_pos == fbm_pkg::FB_PARITY) return ^b;
        return b[frame_pos - fbm_pkg::FB_DATA0];
    endfunction

    function automatic void start_tone_bit(logic v);
        cmp_val = v ? regs.half_period_one : regs.half_period_zero;
        line_q  = v;
        if (tick_ctr >= cmp_val) tick_ctr = cmp_val - 16'd1;
        bit_ctr = '0;
    endfunction

    function automatic void stop_tx();
        tone_a_q  = 1'b0;
        tone_b_q  = 1'b0;
        tx_on     = 1'b0;
        lead_q    = 1'b0;
        cmp_val   = regs.timeout_ticks;
        msg_len   = 0;
        byte_pos  = 0;
        frame_pos = 0;
        bit_ctr   = '0;
    endfunction

    function automatic void next_frame_bit();
        if (lead_q) begin
            lead_q    = 1'b0;
            byte_pos  = 0;
            frame_pos = 0;
        end else begin
            frame_pos++;
            if (frame_pos >= fbm_pkg::FRAME_BITS) begin
                frame_pos = 0;
                byte_pos++;
            end
        end
        if (byte_pos >= msg_len) stop_tx();
        else start_tone_bit(frame_level());
    endfunction

    function automatic void modem_tick(logic fell);
        logic       took;
        logic [2:0] h;
        took = 1'b0;
        if (!tx_on && fell && tick_ctr >= regs.min_gap) begin
            took = 1'b1;
            if (tick_ctr < regs.timeout_ticks) begin
                h       = {rx_hist[1:0], tick_ctr > regs.bit_threshold};
                rx_hist = h;
                line_q  = (h < 3'd3) || (h == 3'd4);
                rx_bits++;
            end
        end
        tick_ctr = took ? 16'd0 : tick_ctr + 16'd1;
        if (tick_ctr == cmp_val) begin
            tick_ctr = regs.reload_value;
            rx_hist  = '0;
            if (tx_on) begin
                tone_a_q = ~tone_a_q;
                tone_b_q = ~tone_b_q;
            end else begin
                line_q = 1'b1;
                hb_q   = ~hb_q;
                rx_timeouts++;
            end
        end
        if (tx_on) begin
            bit_ctr = bit_ctr + 16'd1;
            if (bit_ctr >= regs.bit_ticks) next_frame_bit();
        end
    endfunction

    function automatic void modem_load(logic [7:0] b, logic last);
        if (tx_on) return;
        if (msg_len < fbm_pkg::MAX_BYTES) begin
            msg_mem[msg_len] = b;
            msg_len++;
        end
        if (last && msg_len > 0) begin
            tone_a_q  = 1'b1;
            tone_b_q  = 1'b0;
            tx_on     = 1'b1;
            lead_q    = 1'b1;
            byte_pos  = 0;
            frame_pos = 0;
            tick_ctr  = '0;
            start_tone_bit(1'b1);
            tx_messages++;
        end
    endfunction

    function automatic fbm_pkg::out_item_t modem_step(fbm_pkg::in_item_t it);
        fbm_pkg::out_item_t r;
        if (it.opcode == OP_LOAD) modem_load(it.send_byte, it.last_byte);
        else modem_tick(it.rx_falling_edge);
        r.data_out     = line_q;
        r.drive_a      = tone_a_q;
        r.drive_b      = tone_b_q;
        r.drive_enable = tx_on;
        r.heartbeat    = hb_q;
        r.busy_res     = tx_on;
        return r;
    endfunction

    function automatic void flag_error(string msg);
        errors++;
        if (errors <= 10) $display("ERROR cycle %0d: %s", cycle_count, msg);
    endfunction

    function automatic void check_result(fbm_pkg::out_item_t got);
        fbm_pkg::out_item_t want;
        if (expected_outputs.size() == 0) begin
            flag_error("result transfer with nothing expected");
            return;
        end
        want = expected_outputs.pop_front();
        results_done++;
        if (got.data_out !== want.data_out || got.drive_a !== want.drive_a ||
            got.drive_b !== want.drive_b || got.drive_enable !== want.drive_enable ||
            got.heartbeat !== want.heartbeat || got.busy_res !== want.busy_res) begin
            flag_error($sformatf({"result %0d data/a/b/en/hb/busy: expected %b%b%b%b%b%b",
                                  " got %b%b%b%b%b%b"}, results_done,
                                 want.data_out, want.drive_a, want.drive_b,
                                 want.drive_enable, want.heartbeat, want.busy_res,
                                 got.data_out, got.drive_a, got.drive_b,
                                 got.drive_enable, got.heartbeat, got.busy_res));
        end
    endfunction

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (aresetn) begin
            if (s_valid && s_ready) begin
                expected_outputs.push_back(modem_step(s_data));
                holding = 1'b0;
                items_taken++;
            end
            if (m_valid && m_ready) check_result(m_data);
        end
    end

    always @(negedge aclk) begin
        if (aresetn && !holding) begin
            if (input_backlog.size() > 0 && $urandom_range(99) >= s_idle_pct) begin
                s_data  <= input_backlog.pop_front();
                s_valid <= 1'b1;
                holding = 1'b1;
            end else begin
                s_valid <= 1'b0;
            end
        end
        m_ready <= aresetn ? ($urandom_range(99) >= m_idle_pct) : 1'b0;
    end

    initial begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("fsk_bus_modem_unit: mismatch");
        $finish;
    end

    function automatic fbm_pkg::in_item_t tick_item(logic fell);
        fbm_pkg::in_item_t it;
        it.opcode          = OP_TICK;
        it.rx_falling_edge = fell;
        it.send_byte       = 8'($urandom);
        it.last_byte       = 1'($urandom);
        return it;
    endfunction

    function automatic fbm_pkg::in_item_t load_item(logic [7:0] b, logic last);
        fbm_pkg::in_item_t it;
        it.opcode          = OP_LOAD;
        it.rx_falling_edge = 1'($urandom);
        it.send_byte       = b;
        it.last_byte       = last;
        return it;
    endfunction

    task automatic send_item(fbm_pkg::in_item_t it);
        int ticket;
        ticket = items_queued;
        items_queued++;
        input_backlog.push_back(it);
        wait (items_taken > ticket);
    endtask

    task automatic wait_drain();
        wait (items_taken == items_queued && results_done == items_taken);
        @(negedge aclk);
    endtask

    task automatic cfg_write(fbm_pkg::reg_idx_t idx, logic [15:0] v);
        @(negedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= fbm_pkg::ADDR_W'(4 * int'(idx));
        pwdata  <= {16'h0000, v};
        @(negedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        modem_write(idx, v);
        @(negedge aclk);
        pwrite  <= 1'b0;
        penable <= 1'b0;
        @(negedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        if (prdata[15:0] !== v)
            flag_error($sformatf("register %0d read %h, written %h", idx, prdata, v));
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic run_gap(int gap);
        repeat (gap - 1) send_item(tick_item(1'b0));
        send_item(tick_item(1'b1));
    endtask

    task automatic finish_message();
        while (tx_on) send_item(tick_item(1'($urandom)));
    endtask

    task automatic test_default_receive();
        send_item(tick_item(1'b1));
        run_gap(50);
        run_gap(160);
        run_gap(340);
        repeat (510) send_item(tick_item(1'b0));
    endtask

    task automatic test_send_frames();
        int k;
        wait_drain();
        cfg_write(fbm_pkg::REG_MIN_GAP, 16'd4);
        cfg_write(fbm_pkg::REG_BIT_THRESHOLD, 16'd10);
        cfg_write(fbm_pkg::REG_TIMEOUT_TICKS, 16'd40);
        cfg_write(fbm_pkg::REG_BIT_TICKS, 16'd2);
        cfg_write(fbm_pkg::REG_HALF_PERIOD_ONE, 16'd3);
        cfg_write(fbm_pkg::REG_HALF_PERIOD_ZERO, 16'd5);
        cfg_write(fbm_pkg::REG_RELOAD_VALUE, 16'd0);
        send_item(load_item(8'h00, 1'b0));
        send_item(load_item(8'hFF, 1'b1));
        send_item(load_item(8'hA5, 1'b1));
        send_item(tick_item(1'b1));
        finish_message();
        // full store, extra byte dropped, last still starts
        wait_drain();
        cfg_write(fbm_pkg::REG_BIT_TICKS, 16'd1);
        for (k = 0; k < fbm_pkg::MAX_BYTES + 1; k++)
            send_item(load_item(8'(k * 37 + 1), 1'b0));
        send_item(load_item(8'h5A, 1'b1));
        finish_message();
        // zero bit length and zero half period
        wait_drain();
        cfg_write(fbm_pkg::REG_BIT_TICKS, 16'd0);
        cfg_write(fbm_pkg::REG_HALF_PERIOD_ZERO, 16'd0);
        send_item(load_item(8'h00, 1'b1));
        finish_message();
    endtask

    task automatic test_register_extremes();
        wait_drain();
        cfg_write(fbm_pkg::REG_MIN_GAP, 16'd0);
        cfg_write(fbm_pkg::REG_BIT_THRESHOLD, 16'd0);
        cfg_write(fbm_pkg::REG_TIMEOUT_TICKS, 16'hFFFF);
        cfg_write(fbm_pkg::REG_BIT_TICKS, 16'hFFFF);
        repeat (12) send_item(tick_item(1'b1));
        repeat (4) send_item(tick_item(1'b0));
        wait_drain();
        cfg_write(fbm_pkg::REG_TIMEOUT_TICKS, 16'd1);
        cfg_write(fbm_pkg::REG_RELOAD_VALUE, 16'hFFFF);
        cfg_write(fbm_pkg::REG_BIT_THRESHOLD, 16'hFFFF);
        repeat (20) send_item(tick_item(1'($urandom)));
        wait_drain();
        cfg_write(fbm_pkg::REG_MIN_GAP, 16'hFFFF);
        repeat (20) send_item(tick_item(1'($urandom)));
        wait_drain();
        cfg_write(fbm_pkg::REG_HALF_PERIOD_ONE, 16'hFFFF);
        cfg_write(fbm_pkg::REG_HALF_PERIOD_ZERO, 16'd1);
        cfg_write(fbm_pkg::REG_BIT_TICKS, 16'd1);
        cfg_write(fbm_pkg::REG_RELOAD_VALUE, 16'd0);
        cfg_write(fbm_pkg::REG_MIN_GAP, 16'd3);
        cfg_write(fbm_pkg::REG_BIT_THRESHOLD, 16'd8);
        cfg_write(fbm_pkg::REG_TIMEOUT_TICKS, 16'd40);
        send_item(load_item(8'hC3, 1'b1));
        finish_message();
    endtask

    task automatic test_random_receive();
        int ph;
        int gmin;
        int thr;
        int tmo;
        int pick;
        int gap;
        int budget;
        for (ph = 0; ph < 3; ph++) begin
            wait_drain();
            gmin = $urandom_range(2, 8);
            thr  = gmin + $urandom_range(0, 8);
            tmo  = thr + $urandom_range(2, 12);
            cfg_write(fbm_pkg::REG_MIN_GAP, 16'(gmin));
            cfg_write(fbm_pkg::REG_BIT_THRESHOLD, 16'(thr));
            cfg_write(fbm_pkg::REG_TIMEOUT_TICKS, 16'(tmo));
            cfg_write(fbm_pkg::REG_RELOAD_VALUE, 16'($urandom_range(0, gmin)));
            budget = items_queued + 60;
            while (items_queued < budget) begin
                pick = $urandom_range(99);
                if (pick < 70) gap = $urandom_range(gmin + 1, tmo);
                else if (pick < 85) gap = $urandom_range(1, gmin);
                else gap = $urandom_range(tmo + 1, 2 * tmo);
                run_gap(gap);
            end
        end
    endtask

    task automatic test_random_send();
        int budget;
        int len;
        int k;
        logic first;
        first  = 1'b1;
        budget = items_queued + 250;
        // no idling on either side for the first stretch
        s_idle_pct = 0;
        m_idle_pct = 0;
        while (items_queued < budget) begin
            if (items_queued > budget - 120) begin
                s_idle_pct = IDLE_PCT;
                m_idle_pct = IDLE_PCT;
            end
            if (first || $urandom_range(3) == 0) begin
                wait_drain();
                cfg_write(fbm_pkg::REG_BIT_TICKS, 16'($urandom_range(1, 3)));
                cfg_write(fbm_pkg::REG_HALF_PERIOD_ONE, 16'($urandom_range(1, 6)));
                cfg_write(fbm_pkg::REG_HALF_PERIOD_ZERO, 16'($urandom_range(1, 6)));
                cfg_write(fbm_pkg::REG_RELOAD_VALUE, 16'($urandom_range(0, 3)));
                first = 1'b0;
            end
            len = ($urandom_range(9) == 0)
                ? $urandom_range(fbm_pkg::MAX_BYTES - 1, fbm_pkg::MAX_BYTES + 2)
                : $urandom_range(1, 4);
            for (k = 0; k < len; k++) begin
                send_item(load_item(8'($urandom), k == len - 1));
                if ($urandom_range(4) == 0) send_item(tick_item(1'($urandom)));
            end
            while (tx_on) begin
                if ($urandom_range(19) == 0) send_item(load_item(8'($urandom), 1'($urandom)));
                else send_item(tick_item($urandom_range(3) == 0));
            end
            repeat ($urandom_range(0, 6)) send_item(tick_item(1'($urandom)));
        end
    endtask

    initial begin
        aresetn      = 1'b0;
        s_valid      = 1'b0;
        s_data       = '0;
        m_ready      = 1'b0;
        psel         = 1'b0;
        penable      = 1'b0;
        pwrite       = 1'b0;
        paddr        = '0;
        pwdata       = '0;
        holding      = 1'b0;
        s_idle_pct   = IDLE_PCT;
        m_idle_pct   = IDLE_PCT;
        items_queued = 0;
        items_taken  = 0;
        results_done = 0;
        errors       = 0;
        cycle_count  = 0;
        tx_messages  = 0;
        rx_bits      = 0;
        rx_timeouts  = 0;
        modem_reset();
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        test_default_receive();
        test_send_frames();
        test_register_extremes();
        test_random_receive();
        test_random_send();

        wait_drain();
        repeat (8) @(posedge aclk);
        errors += expected_outputs.size();
        $display("run covered %0d input transfers and %0d checked results", items_taken,
                 results_done);
        $display("  %0d messages framed, %0d bits decoded, %0d receive timeouts", tx_messages,
                 rx_bits, rx_timeouts);
        if (errors == 0) begin
            $display("fsk_bus_modem_unit: match");
        end else begin
            $display("fsk_bus_modem_unit: mismatch");
        end
        $finish;
    end

endmodule
